@@ sv/stbs_pkg.sv @@
package stbs_pkg;

    // field widths of the transfer items
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int CMP_W = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [CMP_W-1:0] comparisons;
        logic             full_error;
    } t_out_item;

    // command broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic cmp_en;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_DONE
    } t_state;

endpackage

@@ sv/stbs_cell.sv @@
module stbs_cell import stbs_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic signed [VAL_W-1:0] i_key,
    input  logic                    i_live,
    input  logic signed [VAL_W-1:0] i_prev_value,
    input  logic                    i_prev_le,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_le,
    output logic                    o_gt,
    output logic                    o_eq
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    r_gt;
    logic                    r_eq;
    logic                    w_le;

    // entry stays if it is live and not above the key
    assign w_le = i_live && (r_value <= i_key);

    // keep, take the key, or take the left neighbor's value
    always_comb begin
        if (w_le) begin
            n_value = r_value;
        end else if (i_prev_le) begin
            n_value = i_key;
        end else begin
            n_value = i_prev_value;
        end
    end

    // entry storage and registered compare flags for the search
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en) begin
            r_value <= n_value;
        end
        if (i_cmd.cmp_en) begin
            r_gt <= (r_value > i_key);
            r_eq <= (r_value == i_key);
        end
    end

    assign o_value = r_value;
    assign o_le    = w_le;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;

endmodule

@@ sv/sorted_table_binary_search_unit.sv @@
// Sorted table of signed 32-bit values with binary search. The table is a row of
// TABLE_DEPTH cells, one entry each; an insert shifts every entry above the new value
// one cell to the right all at once, keeping the row in ascending order with
// equal values in arrival order. Clear and insert pass through the execute and done
// states before the result is registered at the output. A search first latches each
// cell's compare against the key, then walks the binary search (midpoint (low+high)/2)
// one midpoint per cycle over those flags until a hit or an empty range, then goes
// to the done state. One item is in work at a time; the next input transfer is taken
// while the previous result still waits in the output register.
module sorted_table_binary_search_unit import stbs_pkg::*; #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_key;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           n_lo;
    logic [CW-1:0]           r_hi_ex;
    logic [CW-1:0]           n_hi_ex;
    logic [CMP_W-1:0]        r_comps;
    logic [CMP_W-1:0]        n_comps;
    t_out_item               r_res;
    t_out_item               n_res;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    t_cell_cmd               w_cmd;
    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_range_open;
    logic                    w_full;
    logic [CW:0]             w_sum;
    logic [CW-1:0]           w_mid;
    logic [CW:0]             w_mid_p1;
    logic [AW-1:0]           w_mid_idx;
    logic [TABLE_DEPTH-1:0]  w_live;
    logic [TABLE_DEPTH-1:0]  w_le;
    logic [TABLE_DEPTH-1:0]  w_gt;
    logic [TABLE_DEPTH-1:0]  w_eq;
    logic signed [VAL_W-1:0] w_value [TABLE_DEPTH];

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_full      = (r_count == CW'(TABLE_DEPTH));

    // midpoint of the open range [lo, hi_ex)
    assign w_range_open = (r_hi_ex > r_lo);
    assign w_sum        = {1'b0, r_lo} + {1'b0, r_hi_ex} - {{CW{1'b0}}, 1'b1};
    assign w_mid        = w_sum[CW:1];
    assign w_mid_p1     = {1'b0, w_mid} + {{CW{1'b0}}, 1'b1};
    assign w_mid_idx    = w_mid[AW-1:0];

    // row of cells
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic signed [VAL_W-1:0] w_prev_value;
            logic                    w_prev_le;
            if (g == 0) begin : g_head
                assign w_prev_value = r_key;
                assign w_prev_le    = 1'b1;
            end else begin : g_body
                assign w_prev_value = w_value[g-1];
                assign w_prev_le    = w_le[g-1];
            end
            assign w_live[g] = (CW'(g) < r_count);
            stbs_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_key        (r_key),
                .i_live       (w_live[g]),
                .i_prev_value (w_prev_value),
                .i_prev_le    (w_prev_le),
                .o_value      (w_value[g]),
                .o_le         (w_le[g]),
                .o_gt         (w_gt[g]),
                .o_eq         (w_eq[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_SEARCH) begin
                    n_state = S_SRCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                if (!w_range_open || w_eq[w_mid_idx]) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cell commands and sequencer datapath
    always_comb begin
        w_cmd   = '0;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi_ex = r_hi_ex;
        n_comps = r_comps;
        n_res   = r_res;
        case (r_state)
            S_EXEC: begin
                n_res   = '0;
                n_lo    = '0;
                n_hi_ex = r_count;
                n_comps = '0;
                case (r_op)
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    OP_INSERT: begin
                        if (w_full) begin
                            n_res.full_error = 1'b1;
                        end else begin
                            w_cmd.ins_en = 1'b1;
                            n_count      = r_count + {{(CW-1){1'b0}}, 1'b1};
                        end
                    end
                    OP_SEARCH: begin
                        w_cmd.cmp_en = 1'b1;
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
            end
            S_SRCH: begin
                if (w_range_open) begin
                    n_comps = r_comps + {{(CMP_W-1){1'b0}}, 1'b1};
                    if (w_eq[w_mid_idx]) begin
                        n_res.found    = 1'b1;
                        n_res.position = POS_W'(w_mid_p1);
                    end else if (w_gt[w_mid_idx]) begin
                        n_hi_ex = w_mid;
                    end else begin
                        n_lo = w_mid_p1[CW-1:0];
                    end
                    n_res.comparisons = n_comps;
                end else begin
                    n_res.comparisons = r_comps;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op  <= i_in_data.op;
            r_key <= i_in_data.value;
        end
        r_lo    <= n_lo;
        r_hi_ex <= n_hi_ex;
        r_comps <= n_comps;
        r_res   <= n_res;
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_hi_ex <= r_count))
        else $error("search range beyond live entries");

    a_found_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> (o_out_data.comparisons != '0))
        else $error("hit reported without a comparison");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.full_error |->
            (!o_out_data.found && o_out_data.comparisons == '0))
        else $error("full error mixed with search result");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_EXEC))
        else $error("input transfer did not start execution");

endmodule

@@ sim/sorted_table_binary_search_unit_tb.sv @@
module sorted_table_binary_search_unit_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_UNITS = 6_000_000;

    // the op code that the block ignores
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int INT_MIN = 32'sh8000_0000;
    localparam int INT_MAX = 32'sh7FFF_FFFF;
    localparam t_out_item NO_RESULT = '0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item res;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    // shadow copy of the sorted table
    int tbl_vals [TABLE_DEPTH];
    int tbl_count;

    t_out_item table_results_due[$];
    t_stim_row stim_rows[$];
    int        mismatches;

    // typed expectation for the item currently offered
    bit        typed_on;
    t_out_item typed_res;

    // idling control
    int tx_pct;
    int rx_pct;
    bit hold_req;
    int hold_left;

    sorted_table_binary_search_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // apply one operation to the shadow table and return its result
    function automatic t_out_item predict_table_op(t_in_item it);
        t_out_item r;
        int key;
        int pos;
        int lo;
        int hi;
        int mid;
        int steps;
        bit hit;
        r = NO_RESULT;
        key = it.value;
        case (it.op)
            OP_CLEAR: begin
                tbl_count = 0;
            end
            OP_INSERT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.full_error = 1'b1;
                end else begin
                    // new value goes after any equal ones
                    pos = 0;
                    while (pos < tbl_count && tbl_vals[pos] <= key) pos++;
                    for (int k = tbl_count; k > pos; k--) tbl_vals[k] = tbl_vals[k-1];
                    tbl_vals[pos] = key;
                    tbl_count++;
                end
            end
            OP_SEARCH: begin
                lo = 0;
                hi = tbl_count - 1;
                steps = 0;
                hit = 1'b0;
                while (!hit && hi >= lo) begin
                    mid = (lo + hi) / 2;
                    steps++;
                    if (tbl_vals[mid] == key) begin
                        hit = 1'b1;
                        r.found = 1'b1;
                        r.position = POS_W'(mid + 1);
                    end else if (tbl_vals[mid] > key) begin
                        hi = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                r.comparisons = CMP_W'(steps);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // small pool for duplicates, extremes, and full-range values
    function automatic int rand_value();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return int'($urandom_range(16)) - 8;
        if (pick == 4) begin
            case ($urandom_range(3))
                0: return INT_MIN;
                1: return INT_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return int'($urandom);
    endfunction

    // search keys mostly taken from the table, sometimes one off
    function automatic int rand_key();
        int pick;
        int key;
        pick = $urandom_range(9);
        if (tbl_count > 0 && pick < 6) begin
            key = tbl_vals[$urandom_range(tbl_count - 1)];
            if (pick == 5) key = key + 1;
            return key;
        end
        return rand_value();
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int r;
        r = $urandom_range(99);
        it.value = rand_value();
        if (r < 45) begin
            it.op = OP_INSERT;
        end else if (r < 90) begin
            it.op = OP_SEARCH;
            it.value = rand_key();
        end else if (r < 94) begin
            it.op = OP_CLEAR;
        end else begin
            it.op = OP_UNUSED;
        end
        return it;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, int value, bit typed, t_out_item res);
        t_stim_row row;
        row.item.op = op;
        row.item.value = value;
        row.typed = typed;
        row.res = res;
        stim_rows.push_back(row);
    endtask

    // offer one item, starting and ending at a falling edge
    task automatic send(t_in_item it, bit typed, t_out_item res);
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_on = typed;
        typed_res = res;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (table_results_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
            mismatches++;
        end
    endtask

    // result check and prediction on each rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (table_results_due.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $time, got);
                    mismatches++;
                end else begin
                    want = table_results_due.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("position", want.position, got.position);
                    check_field("comparisons", want.comparisons, got.comparisons);
                    check_field("full_error", want.full_error, got.full_error);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = predict_table_op(i_in_data);
                if (typed_on) want = typed_res;
                table_results_due.push_back(want);
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_UNITS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_in_item it;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        tbl_count = 0;
        mismatches = 0;
        typed_on = 1'b0;
        typed_res = NO_RESULT;
        hold_req = 1'b0;
        hold_left = 0;
        tx_pct = 30;
        rx_pct = 61;

        // directed table: empty search, extremes, duplicates, misses, unused op, clear
        add_row(OP_SEARCH, 0, 1'b1, NO_RESULT);
        add_row(OP_UNUSED, 0, 1'b1, NO_RESULT);
        add_row(OP_INSERT, 0, 1'b1, NO_RESULT);
        add_row(OP_SEARCH, 0, 1'b1, {1'b1, 8'd1, 4'd1, 1'b0});
        add_row(OP_INSERT, INT_MIN, 1'b1, NO_RESULT);
        add_row(OP_INSERT, INT_MAX, 1'b1, NO_RESULT);
        add_row(OP_INSERT, -1, 1'b1, NO_RESULT);
        add_row(OP_INSERT, 0, 1'b1, NO_RESULT);
        add_row(OP_SEARCH, INT_MIN, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, INT_MAX, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, -1, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, 0, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, 1, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, 32'sh7FFF_FFFE, 1'b0, NO_RESULT);
        add_row(OP_UNUSED, -1, 1'b1, NO_RESULT);
        add_row(OP_INSERT, 32'sh5555_5555, 1'b1, NO_RESULT);
        add_row(OP_INSERT, 32'shAAAA_AAAA, 1'b1, NO_RESULT);
        add_row(OP_SEARCH, 32'shAAAA_AAAA, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, 32'sh5555_5555, 1'b0, NO_RESULT);
        add_row(OP_CLEAR, INT_MAX, 1'b1, NO_RESULT);
        add_row(OP_SEARCH, 0, 1'b1, NO_RESULT);
        add_row(OP_INSERT, 5, 1'b1, NO_RESULT);
        add_row(OP_SEARCH, 4, 1'b0, NO_RESULT);
        add_row(OP_SEARCH, 6, 1'b0, NO_RESULT);

        // synchronous reset
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) send(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);

        // fill the table to capacity, overfill, then search the full table
        it.op = OP_CLEAR;
        it.value = 0;
        send(it, 1'b0, NO_RESULT);
        for (int n = 0; n < TABLE_DEPTH + 3; n++) begin
            it.op = OP_INSERT;
            it.value = rand_value();
            send(it, 1'b0, NO_RESULT);
        end
        for (int n = 0; n < 30; n++) begin
            it.op = OP_SEARCH;
            it.value = rand_key();
            send(it, 1'b0, NO_RESULT);
        end
        drain();

        // random phases: receiver idles most, then sender idles most, then neither but one long receiver hold
        for (int phase = 0; phase < 3; phase++) begin
            tx_pct = (phase == 0) ? 30 : (phase == 1) ? 61 : 0;
            rx_pct = (phase == 0) ? 61 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == 2 && n == 10) hold_req = 1'b1;
                send(rand_item(), 1'b0, NO_RESULT);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, table_results_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
